// ===== hw/rtl/apic_pkg.sv =====
// Shared types and constants for the local APIC priority controller.
`timescale 1ns / 1ps

package apic_pkg;

   localparam int WORD_BITS = 32;
   localparam int WORD_LOG  = 5;

   localparam logic [1:0] REQ_INJECT = 2'd0;
   localparam logic [1:0] REQ_TPR    = 2'd1;
   localparam logic [1:0] REQ_EOI    = 2'd2;
   localparam logic [1:0] REQ_PPR    = 2'd3;

   typedef struct packed {
      logic accept;
      logic apply;
      logic scan_word;
      logic scan_bit;
      logic retire;
      logic decide;
      logic sel_isr;
   } cmd_type;

   typedef struct packed {
      logic map_nonempty;
   } sts_type;

endpackage

// ===== hw/rtl/apic_ctrl.sv =====
// Sequencer for the local APIC priority controller: request flow and result register.
`timescale 1ns / 1ps

module apic_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output apic_pkg::cmd_type cmd,
   input  apic_pkg::sts_type sts
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_APPLY  = 3'd1;
   localparam logic [2:0] ST_WORD   = 3'd2;
   localparam logic [2:0] ST_BIT    = 3'd3;
   localparam logic [2:0] ST_RETIRE = 3'd4;
   localparam logic [2:0] ST_DECIDE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] type_ff, type_in;
   logic       sel_isr_ff, sel_isr_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      type_in    = type_ff;
      sel_isr_in = sel_isr_ff;
      cmd        = '0;
      cmd.sel_isr = sel_isr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               type_in    = req_type;
               if (req_type == apic_pkg::REQ_INJECT || req_type == apic_pkg::REQ_TPR) begin
                  sel_isr_in = 1'b0;
                  state_in   = ST_APPLY;
               end else begin
                  sel_isr_in = 1'b1;
                  state_in   = ST_WORD;
               end
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_WORD;
         end
         ST_WORD: begin
            cmd.scan_word = 1'b1;
            state_in      = ST_BIT;
         end
         ST_BIT: begin
            cmd.scan_bit = 1'b1;
            if (type_ff == apic_pkg::REQ_EOI && sel_isr_ff && sts.map_nonempty) begin
               state_in = ST_RETIRE;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_RETIRE: begin
            cmd.retire = 1'b1;
            sel_isr_in = 1'b0;
            state_in   = ST_WORD;
         end
         ST_DECIDE: begin
            if (out_free) begin
               cmd.decide = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.decide ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         type_ff      <= apic_pkg::REQ_INJECT;
         sel_isr_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         type_ff      <= type_in;
         sel_isr_ff   <= sel_isr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/apic_dp.sv =====
// Datapath for the local APIC priority controller: IRR/ISR/TPR state, scan unit, result.
`timescale 1ns / 1ps

module apic_dp #(
   parameter int VECTOR_WORDS  = 8,
   parameter int LOWEST_VECTOR = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  apic_pkg::cmd_type cmd,
   output apic_pkg::sts_type sts,
   input  logic              csr_we,
   input  logic              csr_apic_enabled,
   input  logic [1:0]        req_type,
   input  logic [7:0]        req_vector,
   input  logic [7:0]        req_tpr_value,
   input  logic              req_cpu_can_take,
   input  logic              req_slot_busy,
   output logic              rsp_inject_valid,
   output logic [7:0]        rsp_inject_vector,
   output logic              rsp_accepted,
   output logic              rsp_wait_window,
   output logic              rsp_eoi_valid,
   output logic [7:0]        rsp_eoi_vector,
   output logic [7:0]        rsp_ppr
);

   localparam int NV = VECTOR_WORDS * apic_pkg::WORD_BITS;
   localparam int VB = $clog2(NV);
   localparam int WW = (VECTOR_WORDS > 1) ? $clog2(VECTOR_WORDS) : 1;

   logic [NV-1:0] pend_ff, pend_in;
   logic [NV-1:0] isr_ff, isr_in;
   logic [7:0]    tpr_ff;
   logic          enabled_ff;

   logic [1:0]    type_ff;
   logic [7:0]    vector_ff;
   logic [7:0]    tpr_value_ff;
   logic          can_take_ff;
   logic          slot_busy_ff;
   logic          tpr_changed_ff;
   logic          eoi_hit_ff;
   logic [7:0]    eoi_vec_ff;

   logic [WW-1:0] widx_ff;
   logic [31:0]   word_ff;
   logic          any_ff;
   logic          hit_ff;
   logic [7:0]    vec_ff;

   logic [NV-1:0] map;
   logic [WW-1:0] widx;
   logic          any;
   logic [2:0]    nib;
   logic [3:0]    nib_bits;
   logic [1:0]    bsel;

   logic          inj_ok;
   logic          elig;
   logic          raise_ok;
   logic          can_deliver;
   logic          go;
   logic          deliver;
   logic          wait_win;
   logic [3:0]    isr_class;
   logic [3:0]    tpr_class;
   logic [3:0]    cls;
   logic [3:0]    sub;

   assign sts.map_nonempty = any_ff;

   // word level of the scan: highest nonzero word
   always_comb begin
      map  = cmd.sel_isr ? isr_ff : pend_ff;
      widx = '0;
      any  = 1'b0;
      for (int w = 0; w < VECTOR_WORDS; w++) begin
         if (|map[w*apic_pkg::WORD_BITS +: apic_pkg::WORD_BITS]) begin
            widx = WW'(w);
            any  = 1'b1;
         end
      end
   end

   // bit level of the scan: highest nibble, then highest bit in it
   always_comb begin
      nib  = '0;
      bsel = '0;
      for (int n = 0; n < 8; n++) begin
         if (|word_ff[n*4 +: 4]) begin
            nib = 3'(n);
         end
      end
      nib_bits = word_ff[nib*4 +: 4];
      for (int b = 0; b < 4; b++) begin
         if (nib_bits[b]) begin
            bsel = 2'(b);
         end
      end
   end

   always_comb begin
      inj_ok = enabled_ff
            && (vector_ff >= 8'(LOWEST_VECTOR))
            && ({5'b0, vector_ff[7:5]} < 8'(VECTOR_WORDS));
      elig        = hit_ff && (vec_ff[7:4] > tpr_ff[7:4]);
      raise_ok    = enabled_ff && (vec_ff >= 8'(LOWEST_VECTOR));
      can_deliver = elig && !isr_ff[vec_ff[VB-1:0]] && !slot_busy_ff;
      go          = 1'b0;
      deliver     = 1'b0;
      wait_win    = 1'b0;
      case (type_ff)
         apic_pkg::REQ_INJECT: begin
            deliver  = inj_ok && can_take_ff && can_deliver;
            wait_win = inj_ok && !can_take_ff;
         end
         apic_pkg::REQ_TPR: begin
            go      = tpr_changed_ff && can_take_ff && elig && raise_ok;
            deliver = go && can_deliver;
         end
         apic_pkg::REQ_EOI: begin
            go       = eoi_hit_ff && elig && raise_ok;
            deliver  = go && can_take_ff && can_deliver;
            wait_win = go && !can_take_ff;
         end
         default: begin
            go = 1'b0;
         end
      endcase
      // PPR: class is max of TPR and top ISR class, subclass only when TPR wins or ties
      isr_class = hit_ff ? vec_ff[7:4] : 4'd0;
      tpr_class = tpr_ff[7:4];
      cls       = (tpr_class > isr_class) ? tpr_class : isr_class;
      sub       = (tpr_class >= isr_class) ? tpr_ff[3:0] : 4'd0;
   end

   always_comb begin
      pend_in = pend_ff;
      isr_in  = isr_ff;
      if (cmd.apply && type_ff == apic_pkg::REQ_INJECT && inj_ok) begin
         pend_in[vector_ff[VB-1:0]] = 1'b1;
      end
      if (cmd.retire) begin
         isr_in[vec_ff[VB-1:0]] = 1'b0;
      end
      if (cmd.decide && deliver) begin
         pend_in[vec_ff[VB-1:0]] = 1'b0;
         isr_in[vec_ff[VB-1:0]]  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= '0;
         isr_ff     <= '0;
         tpr_ff     <= '0;
         enabled_ff <= 1'b0;
         eoi_hit_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         isr_ff  <= isr_in;
         if (csr_we) begin
            enabled_ff <= csr_apic_enabled;
         end
         if (cmd.apply && type_ff == apic_pkg::REQ_TPR) begin
            tpr_ff <= tpr_value_ff;
         end
         if (cmd.accept) begin
            eoi_hit_ff <= 1'b0;
         end else if (cmd.retire) begin
            eoi_hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff      <= req_type;
         vector_ff    <= req_vector;
         tpr_value_ff <= req_tpr_value;
         can_take_ff  <= req_cpu_can_take;
         slot_busy_ff <= req_slot_busy;
      end
      if (cmd.apply) begin
         tpr_changed_ff <= (tpr_value_ff != tpr_ff);
      end
      if (cmd.retire) begin
         eoi_vec_ff <= vec_ff;
      end
      if (cmd.scan_word) begin
         widx_ff <= widx;
         word_ff <= map[widx*apic_pkg::WORD_BITS +: apic_pkg::WORD_BITS];
         any_ff  <= any;
      end
      if (cmd.scan_bit) begin
         hit_ff <= any_ff;
         vec_ff <= (8'(widx_ff) << apic_pkg::WORD_LOG) | (8'(nib) << 2) | 8'(bsel);
      end
      if (cmd.decide) begin
         rsp_inject_valid  <= deliver;
         rsp_inject_vector <= deliver ? vec_ff : 8'd0;
         rsp_accepted      <= (type_ff == apic_pkg::REQ_INJECT) && inj_ok;
         rsp_wait_window   <= wait_win;
         rsp_eoi_valid     <= (type_ff == apic_pkg::REQ_EOI) && eoi_hit_ff;
         rsp_eoi_vector    <= ((type_ff == apic_pkg::REQ_EOI) && eoi_hit_ff) ? eoi_vec_ff : 8'd0;
         rsp_ppr           <= (type_ff == apic_pkg::REQ_PPR) ? {cls, sub} : 8'd0;
      end
   end

endmodule

// ===== hw/rtl/apic_interrupt_priority_controller_core.sv =====
// Top level of the local APIC priority controller: sequencer plus datapath.
`timescale 1ns / 1ps

// Local APIC interrupt bookkeeping over pending (IRR) and in-service (ISR) bitmaps and the
// task priority. One request is worked on at a time and each gives exactly one result.
// From request transfer to result register load, an inject or TPR write passes through the
// apply, word-scan, bit-scan and decide states; a PPR read or an EOI with nothing in service
// skips the apply state, and an EOI that retires a vector scans, retires and scans again.
// The scan finds the highest nonzero 32-bit word over the bitmap, then the highest bit in it.
// Decide waits until the output register is free, and the block is idle again as it loads.
// A finished result waits in the output register while the next request is taken.
// The enable register is written through the csr channel, which is always ready.

module apic_interrupt_priority_controller_core #(
   parameter int VECTOR_WORDS  = 8,
   parameter int LOWEST_VECTOR = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_apic_enabled,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_vector,
   input  logic [7:0] req_tpr_value,
   input  logic       req_cpu_can_take,
   input  logic       req_slot_busy,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_inject_valid,
   output logic [7:0] rsp_inject_vector,
   output logic       rsp_accepted,
   output logic       rsp_wait_window,
   output logic       rsp_eoi_valid,
   output logic [7:0] rsp_eoi_vector,
   output logic [7:0] rsp_ppr
);

   apic_pkg::cmd_type cmd;
   apic_pkg::sts_type sts;
   logic              csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   apic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   apic_dp #(
      .VECTOR_WORDS  (VECTOR_WORDS),
      .LOWEST_VECTOR (LOWEST_VECTOR)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_we            (csr_we),
      .csr_apic_enabled  (csr_apic_enabled),
      .req_type          (req_type),
      .req_vector        (req_vector),
      .req_tpr_value     (req_tpr_value),
      .req_cpu_can_take  (req_cpu_can_take),
      .req_slot_busy     (req_slot_busy),
      .rsp_inject_valid  (rsp_inject_valid),
      .rsp_inject_vector (rsp_inject_vector),
      .rsp_accepted      (rsp_accepted),
      .rsp_wait_window   (rsp_wait_window),
      .rsp_eoi_valid     (rsp_eoi_valid),
      .rsp_eoi_vector    (rsp_eoi_vector),
      .rsp_ppr           (rsp_ppr)
   );

endmodule

// ===== hw/rtl/apic_chk.sv =====
// Port-level checks for the local APIC priority controller, bound to the top level.
`timescale 1ns / 1ps

module apic_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_inject_valid,
   input logic [7:0] rsp_inject_vector,
   input logic       rsp_accepted,
   input logic       rsp_wait_window,
   input logic       rsp_eoi_valid,
   input logic [7:0] rsp_eoi_vector,
   input logic [7:0] rsp_ppr
);

   // a request transfer keeps the block busy on the following cycle
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block took requests on consecutive cycles");

   a_inject_vector_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_inject_valid |-> rsp_inject_vector == 8'd0)
      else $error("inject vector set without delivery");

   a_eoi_vector_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_eoi_valid |-> rsp_eoi_vector == 8'd0)
      else $error("eoi vector set without retirement");

   a_inject_result_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> !rsp_eoi_valid && rsp_ppr == 8'd0)
      else $error("inject result carries eoi or ppr data");

   a_wait_no_deliver: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wait_window |-> !rsp_inject_valid)
      else $error("window wait flagged together with delivery");

endmodule

bind apic_interrupt_priority_controller_core apic_chk u_apic_chk (.*);

// ===== tb/sv/apic_interrupt_priority_controller_core_tb.sv =====
// Self-checking testbench for the local APIC interrupt priority controller core.
`timescale 1ns / 1ps

module apic_interrupt_priority_controller_core_tb;

   localparam int LOWEST_VECTOR = 32;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int HOLD_AT       = 120;
   localparam int HOLD_CYCLES   = 150;
   localparam logic [4:0] PHASE_ENABLE = 5'b10101;
   localparam int PHASE_ITEMS [5] = '{170, 30, 150, 30, 150};

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] vector;
      logic [7:0] tpr_value;
      logic       cpu_can_take;
      logic       slot_busy;
   } request_type;

   typedef struct packed {
      logic       inject_valid;
      logic [7:0] inject_vector;
      logic       accepted;
      logic       wait_window;
      logic       eoi_valid;
      logic [7:0] eoi_vector;
      logic [7:0] ppr;
   } outcome_type;

   typedef struct packed {
      logic        enable;
      request_type rq;
      logic        typed;
      outcome_type want;
   } step_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_apic_enabled = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_type = apic_pkg::REQ_PPR;
   logic [7:0] req_vector = 8'd0;
   logic [7:0] req_tpr_value = 8'd0;
   logic       req_cpu_can_take = 1'b0;
   logic       req_slot_busy = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_inject_valid;
   logic [7:0] rsp_inject_vector;
   logic       rsp_accepted;
   logic       rsp_wait_window;
   logic       rsp_eoi_valid;
   logic [7:0] rsp_eoi_vector;
   logic [7:0] rsp_ppr;

   // controller state as predicted
   logic [255:0] irr_bits = '0;
   logic [255:0] isr_bits = '0;
   logic [7:0]   tpr_reg = 8'd0;
   logic         enabled_reg = 1'b0;

   outcome_type outcome_q [$];
   int unsigned mismatches = 0;
   int unsigned sent_count = 0;
   int unsigned cycle_count = 0;
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   logic        quiet = 1'b0;

   step_row_type directed_rows [26] = '{
      '{1'b0, '{apic_pkg::REQ_PPR,    8'd0,   8'h00, 1'b1, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   8'h00}},
      '{1'b0, '{apic_pkg::REQ_INJECT, 8'd100, 8'h00, 1'b1, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   8'h00}},
      '{1'b0, '{apic_pkg::REQ_TPR,    8'd0,   8'h2b, 1'b1, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   8'h00}},
      '{1'b0, '{apic_pkg::REQ_EOI,    8'd0,   8'h00, 1'b1, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   8'h00}},
      '{1'b0, '{apic_pkg::REQ_PPR,    8'd0,   8'h00, 1'b0, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   8'h2b}},
      '{1'b1, '{apic_pkg::REQ_TPR,    8'd0,   8'h00, 1'b0, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   8'h00}},
      '{1'b1, '{apic_pkg::REQ_INJECT, 8'd31,  8'h00, 1'b1, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   8'h00}},
      '{1'b1, '{apic_pkg::REQ_INJECT, 8'd32,  8'h00, 1'b1, 1'b0}, 1'b1,
         '{1'b1, 8'd32,  1'b1, 1'b0, 1'b0, 8'd0,   8'h00}},
      '{1'b1, '{apic_pkg::REQ_INJECT, 8'd255, 8'hff, 1'b0, 1'b1}, 1'b1,
         '{1'b0, 8'd0,   1'b1, 1'b1, 1'b0, 8'd0,   8'h00}},
      '{1'b1, '{apic_pkg::REQ_INJECT, 8'd0,   8'h00, 1'b1, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   8'h00}},
      '{1'b1, '{apic_pkg::REQ_PPR,    8'd255, 8'hff, 1'b1, 1'b1}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   8'h20}},
      '{1'b1, '{apic_pkg::REQ_INJECT, 8'd200, 8'h00, 1'b1, 1'b1}, 1'b1,
         '{1'b0, 8'd0,   1'b1, 1'b0, 1'b0, 8'd0,   8'h00}},
      '{1'b1, '{apic_pkg::REQ_TPR,    8'd0,   8'hff, 1'b1, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   8'h00}},
      '{1'b1, '{apic_pkg::REQ_TPR,    8'd0,   8'hff, 1'b1, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   8'h00}},
      '{1'b1, '{apic_pkg::REQ_TPR,    8'd0,   8'h10, 1'b1, 1'b0}, 1'b1,
         '{1'b1, 8'd255, 1'b0, 1'b0, 1'b0, 8'd0,   8'h00}},
      '{1'b1, '{apic_pkg::REQ_INJECT, 8'd255, 8'h00, 1'b1, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b1, 1'b0, 1'b0, 8'd0,   8'h00}},
      '{1'b1, '{apic_pkg::REQ_EOI,    8'd0,   8'h00, 1'b0, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b1, 1'b1, 8'd255, 8'h00}},
      '{1'b1, '{apic_pkg::REQ_EOI,    8'd0,   8'h00, 1'b1, 1'b0}, 1'b1,
         '{1'b1, 8'd255, 1'b0, 1'b0, 1'b1, 8'd32,  8'h00}},
      '{1'b1, '{apic_pkg::REQ_PPR,    8'd0,   8'h00, 1'b0, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   8'hf0}},
      '{1'b1, '{apic_pkg::REQ_TPR,    8'd0,   8'h3a, 1'b1, 1'b0}, 1'b0, '0},
      '{1'b1, '{apic_pkg::REQ_PPR,    8'd0,   8'h00, 1'b1, 1'b0}, 1'b0, '0},
      '{1'b1, '{apic_pkg::REQ_EOI,    8'd0,   8'h00, 1'b1, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b1, 8'd255, 8'h00}},
      '{1'b1, '{apic_pkg::REQ_PPR,    8'd0,   8'h00, 1'b1, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   8'hc0}},
      '{1'b1, '{apic_pkg::REQ_INJECT, 8'd64,  8'h00, 1'b0, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b1, 1'b1, 1'b0, 8'd0,   8'h00}},
      '{1'b0, '{apic_pkg::REQ_EOI,    8'd0,   8'h00, 1'b0, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b1, 8'd200, 8'h00}},
      '{1'b0, '{apic_pkg::REQ_EOI,    8'd0,   8'h00, 1'b1, 1'b0}, 1'b1,
         '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   8'h00}}
   };

   apic_interrupt_priority_controller_core DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_apic_enabled  (csr_apic_enabled),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_vector        (req_vector),
      .req_tpr_value     (req_tpr_value),
      .req_cpu_can_take  (req_cpu_can_take),
      .req_slot_busy     (req_slot_busy),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_inject_valid  (rsp_inject_valid),
      .rsp_inject_vector (rsp_inject_vector),
      .rsp_accepted      (rsp_accepted),
      .rsp_wait_window   (rsp_wait_window),
      .rsp_eoi_valid     (rsp_eoi_valid),
      .rsp_eoi_vector    (rsp_eoi_vector),
      .rsp_ppr           (rsp_ppr)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // {found, index} of the highest set bit
   function automatic logic [8:0] highest_bit(input logic [255:0] map);
      for (int i = 255; i >= 0; i--) begin
         if (map[i]) return {1'b1, 8'(i)};
      end
      return 9'd0;
   endfunction

   function automatic logic find_eligible(output logic [7:0] vec);
      logic [8:0] top;
      top = highest_bit(irr_bits);
      vec = top[7:0];
      return top[8] && (top[7:4] > tpr_reg[7:4]);
   endfunction

   function automatic void try_deliver(input logic busy, inout outcome_type oc);
      logic [7:0] vec;
      logic       ok;
      ok = find_eligible(vec);
      if (!ok || isr_bits[vec] || busy) return;
      irr_bits[vec] = 1'b0;
      isr_bits[vec] = 1'b1;
      oc.inject_valid = 1'b1;
      oc.inject_vector = vec;
   endfunction

   function automatic logic raise_vector(input logic [7:0] vec, input logic can_take,
                                         input logic busy, inout outcome_type oc);
      if (vec < LOWEST_VECTOR || !enabled_reg) return 1'b0;
      irr_bits[vec] = 1'b1;
      if (can_take) try_deliver(busy, oc);
      else oc.wait_window = 1'b1;
      return 1'b1;
   endfunction

   function automatic outcome_type predict_outcome(input request_type rq);
      outcome_type oc;
      logic [7:0]  vec;
      logic [7:0]  old_tpr;
      logic [8:0]  top;
      logic [3:0]  isr_cls;
      logic [3:0]  tpr_cls;
      oc = '0;
      case (rq.kind)
         apic_pkg::REQ_INJECT: begin
            oc.accepted = raise_vector(rq.vector, rq.cpu_can_take, rq.slot_busy, oc);
         end
         apic_pkg::REQ_TPR: begin
            old_tpr = tpr_reg;
            tpr_reg = rq.tpr_value;
            if (rq.tpr_value != old_tpr && rq.cpu_can_take && find_eligible(vec))
               void'(raise_vector(vec, rq.cpu_can_take, rq.slot_busy, oc));
         end
         apic_pkg::REQ_EOI: begin
            top = highest_bit(isr_bits);
            if (top[8]) begin
               isr_bits[top[7:0]] = 1'b0;
               oc.eoi_valid = 1'b1;
               oc.eoi_vector = top[7:0];
               if (find_eligible(vec))
                  void'(raise_vector(vec, rq.cpu_can_take, rq.slot_busy, oc));
            end
         end
         default: begin
            top = highest_bit(isr_bits);
            isr_cls = top[7:4];
            tpr_cls = tpr_reg[7:4];
            oc.ppr = {(tpr_cls > isr_cls) ? tpr_cls : isr_cls,
                      (tpr_cls >= isr_cls) ? tpr_reg[3:0] : 4'h0};
         end
      endcase
      return oc;
   endfunction

   function automatic request_type random_request();
      request_type rq;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) rq.kind = apic_pkg::REQ_INJECT;
      else if (pick < 65) rq.kind = apic_pkg::REQ_EOI;
      else if (pick < 88) rq.kind = apic_pkg::REQ_TPR;
      else rq.kind = apic_pkg::REQ_PPR;
      if ($urandom_range(0, 9) == 0) rq.vector = 8'($urandom_range(0, 31));
      else rq.vector = 8'($urandom_range(32, 255));
      if ($urandom_range(0, 3) == 0) rq.tpr_value = 8'($urandom_range(0, 255));
      else rq.tpr_value = 8'($urandom_range(0, 95));
      rq.cpu_can_take = ($urandom_range(0, 3) != 0);
      rq.slot_busy = ($urandom_range(0, 3) == 0);
      return rq;
   endfunction

   task automatic send_request(input request_type rq, input logic typed,
                               input outcome_type want);
      outcome_type oc;
      req_valid <= 1'b1;
      req_type <= rq.kind;
      req_vector <= rq.vector;
      req_tpr_value <= rq.tpr_value;
      req_cpu_can_take <= rq.cpu_can_take;
      req_slot_busy <= rq.slot_busy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      oc = predict_outcome(rq);
      outcome_q.push_back(typed ? want : oc);
      sent_count++;
   endtask

   task automatic idle_for(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outcome_q.size() != 0);
   endtask

   task automatic set_enable(input logic value);
      csr_valid <= 1'b1;
      csr_apic_enabled <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      enabled_reg = value;
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            $display("%0t: result transfer with nothing expected, expected none, actual ppr %0d",
                     $time, rsp_ppr);
            mismatches++;
         end else begin
            want = outcome_q.pop_front();
            check_field("inject_valid", want.inject_valid, rsp_inject_valid);
            check_field("inject_vector", want.inject_vector, rsp_inject_vector);
            check_field("accepted", want.accepted, rsp_accepted);
            check_field("wait_window", want.wait_window, rsp_wait_window);
            check_field("eoi_valid", want.eoi_valid, rsp_eoi_valid);
            check_field("eoi_vector", want.eoi_vector, rsp_eoi_vector);
            check_field("ppr", want.ppr, rsp_ppr);
         end
      end
   end

   // result side back-pressure
   initial begin : rsp_backpressure
      int unsigned n;
      logic        held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && !held && sent_count >= HOLD_AT) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!reset && !quiet && $urandom_range(1, 100) <= stall_pct) begin
            n = $urandom_range(1, 13);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_pct = 30;
      stall_pct = 30;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].enable != enabled_reg) begin
            drain_results();
            set_enable(directed_rows[i].enable);
         end
         send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
         if ($urandom_range(1, 100) <= gap_pct) idle_for($urandom_range(1, 13));
      end

      for (int p = 0; p < 5; p++) begin
         if (PHASE_ENABLE[p] != enabled_reg) begin
            drain_results();
            set_enable(PHASE_ENABLE[p]);
         end
         gap_pct = $urandom_range(0, 40);
         stall_pct = $urandom_range(0, 40);
         for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
            if (p == 0 && i == 60) drain_results();
            if (p == 4 && i == PHASE_ITEMS[p] - 60) quiet = 1'b1;
            send_request(random_request(), 1'b0, '0);
            if (!quiet && $urandom_range(1, 100) <= gap_pct) idle_for($urandom_range(1, 13));
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/apic_pkg.sv
hw/rtl/apic_ctrl.sv
hw/rtl/apic_dp.sv
hw/rtl/apic_interrupt_priority_controller_core.sv
hw/rtl/apic_chk.sv
tb/sv/apic_interrupt_priority_controller_core_tb.sv
